[hdl/assert_macros.svh]
// Assertion helpers for the RTL files, included by hsla_to_rgba_unit.
// Both macros assert on the rising clock edge and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The expression must be true at every clock edge.
`define ASSERT_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// The consequent must be true at the clock edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/hslrgb_pkg.sv]
package hslrgb_pkg;

    // Field widths of the two channels.
    localparam int HUE_W  = 20;
    localparam int Q12_W  = 16;
    localparam int BYTE_W = 8;

    typedef logic signed [HUE_W-1:0] hue_t;
    typedef logic signed [Q12_W-1:0] q12_t;
    typedef logic [BYTE_W-1:0]       byte_t;

    // Offset hue (hue plus a whole number of turns), never negative.
    typedef logic [HUE_W:0] hoff_t;
    // Hue wrapped into one turn, 0 to 23039.
    typedef logic [14:0]    hmod_t;
    // Estimated turn count of the offset hue.
    typedef logic [5:0]     hturn_t;

    // One Q4.12 unit.
    localparam q12_t Q12_ONE = 16'sd4096;

    // 360 degrees with 6 fraction bits, and 360 * 64 = 45 << 9.
    localparam hoff_t HUE_TURN     = 21'd23040;
    localparam int    HUE_DIV      = 45;
    // Bias that lifts the offset-binary hue (hue + 2^19) to hue + 23 turns.
    localparam hoff_t HUE_BIAS     = 21'd5632;
    // floor(2^16 / 45): underestimates the turn count by at most one.
    localparam logic [10:0] HUE_RECIP = 11'd1456;

endpackage

[hdl/hslrgb_in_if.sv]
interface hslrgb_in_if;

    logic                valid;
    logic                ready;
    hslrgb_pkg::hue_t    hue;
    hslrgb_pkg::q12_t    saturation;
    hslrgb_pkg::q12_t    lightness;
    hslrgb_pkg::q12_t    opacity;

    modport source
    (
        output valid,
        output hue,
        output saturation,
        output lightness,
        output opacity,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  hue,
        input  saturation,
        input  lightness,
        input  opacity,
        output ready
    );

endinterface

[hdl/hslrgb_out_if.sv]
interface hslrgb_out_if;

    logic                valid;
    logic                ready;
    hslrgb_pkg::byte_t   red;
    hslrgb_pkg::byte_t   green;
    hslrgb_pkg::byte_t   blue;
    hslrgb_pkg::byte_t   alpha_out;

    modport source
    (
        output valid,
        output red,
        output green,
        output blue,
        output alpha_out,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  red,
        input  green,
        input  blue,
        input  alpha_out,
        output ready
    );

endinterface

[hdl/hsla_to_rgba_unit.sv]
// HSLA to RGBA pixel converter, CSS3 hue-to-RGB method.
// The hsla channel carries one color per transfer: hue in signed degrees with
// 6 fraction bits, saturation, lightness and opacity as signed Q4.12. The rgba
// channel returns one pixel per color: red, green, blue and alpha_out bytes.
// Both channels transfer when valid and ready are high at a rising clk edge.
// rgba.valid rises once the color has passed through every stage and sits in the
// output register. Throughput is one pixel per cycle while rgba.ready is high.
// The datapath is a nine-stage pipeline: turn estimate and input clamping, hue
// wrap with lightness times saturation, hue scaling by a reciprocal multiply
// with q and p, quotient correction, the channel offsets, the ramp selection,
// one multiplier per color channel, the channel clamp, and the byte rounding
// stage that is also the output register.
// Each stage holds a valid bit and loads when it is empty or the stage after it
// moves, so a stalled receiver holds the last stage while empty stages ahead of
// it keep filling; hsla.ready drops only when every stage is full and
// rgba.ready is low. rst_n clears all valid bits asynchronously; no pixel is
// output until a color is accepted after reset.
`include "assert_macros.svh"

module hsla_to_rgba_unit
#(
    parameter int INTERNAL_FRACTION_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    hslrgb_in_if.sink           hsla,
    hslrgb_out_if.source        rgba
);

    localparam int F  = INTERNAL_FRACTION_BITS;
    localparam int NS = 9;
    localparam int NW = F + 6;
    localparam int NCH = 3;

    typedef logic [F-1:0]     frac_t;
    typedef logic [F:0]       unit_t;
    typedef logic [F+1:0]     wide_t;
    typedef logic [F+3:0]     ext_t;
    typedef logic [2*F+1:0]   prod_t;
    typedef logic [NW-1:0]    num_t;
    typedef logic [2*F+6:0]   qprod_t;

    typedef struct packed
    {
        logic  use_q;
        unit_t d;
    } chan_ctl_t;

    localparam int    ONE_I      = 1 << F;
    localparam unit_t ONE        = unit_t'(ONE_I);
    localparam unit_t HALF       = unit_t'(ONE_I / 2);
    localparam unit_t THIRD      = unit_t'(ONE_I / 3);
    localparam unit_t SIXTH      = unit_t'(ONE_I / 6);
    localparam unit_t TWO_THIRDS = unit_t'((2 * ONE_I) / 3);
    localparam int    RECIP_I    = (1 << NW) / hslrgb_pkg::HUE_DIV;
    localparam unit_t HUE_RECIP_F = unit_t'(RECIP_I);

    // Clamp a Q4.12 value to 0..1 and rescale it to F fraction bits.
    function automatic unit_t unit_from_q12(input hslrgb_pkg::q12_t x);
        logic [12:0]   c;
        logic [F+12:0] w;
        if (x[hslrgb_pkg::Q12_W-1])
            c = '0;
        else if (x > hslrgb_pkg::Q12_ONE)
            c = 13'(hslrgb_pkg::Q12_ONE);
        else
            c = x[12:0];
        w = {c, {F{1'b0}}};
        return w[F+12:12];
    endfunction

    // Scale a 0..1 value by 255 and round half up.
    function automatic hslrgb_pkg::byte_t to_byte(input unit_t v);
        logic [F+8:0] acc;
        acc = {v, 8'd0} - {8'd0, v} + {8'd0, HALF};
        return acc[F+7:F];
    endfunction

    // Pick the ramp segment for a channel position t in 0..1.
    function automatic chan_ctl_t chan_ctl(input unit_t t);
        chan_ctl_t c;
        ext_t      six;
        c.use_q = 1'b0;
        c.d     = '0;
        six     = '0;
        if (t < SIXTH)
        begin
            six = ext_t'(t) * ext_t'(6);
            c.d = six[F:0];
        end
        else if (t < HALF)
        begin
            c.use_q = 1'b1;
        end
        else if (t < TWO_THIRDS)
        begin
            six = ext_t'(TWO_THIRDS - t) * ext_t'(6);
            c.d = six[F:0];
        end
        return c;
    endfunction

    // Stage valid bits and load enables.
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] stage_en;

    // Stage 1: offset hue, turn estimate, clamped inputs.
    hslrgb_pkg::hoff_t  s1_hue_next, s1_hue_reg;
    hslrgb_pkg::hturn_t s1_k_next, s1_k_reg;
    unit_t              s1_sat_next, s1_sat_reg;
    unit_t              s1_lit_next, s1_lit_reg;
    unit_t              s1_alpha_next, s1_alpha_reg;
    logic [22:0]        k_prod;

    // Stage 2: wrapped hue, lightness times saturation, alpha byte.
    hslrgb_pkg::hmod_t  s2_hmod_next, s2_hmod_reg;
    unit_t              s2_ls_next, s2_ls_reg;
    unit_t              s2_sat_reg, s2_lit_reg;
    hslrgb_pkg::byte_t  s2_abyte_next, s2_abyte_reg;
    hslrgb_pkg::hoff_t  hue_rem;
    prod_t              ls_prod;

    // Stage 3: hue quotient estimate, q and p.
    num_t               s3_num_next, s3_num_reg;
    frac_t              s3_qhat_next, s3_qhat_reg;
    unit_t              s3_q_next, s3_q_reg;
    unit_t              s3_p_next, s3_p_reg;
    hslrgb_pkg::byte_t  s3_abyte_reg;
    qprod_t             q_prod;
    wide_t              q_wide, p_wide;

    // Stage 4: hue as a fraction of a turn, span q - p.
    frac_t              s4_h_next, s4_h_reg;
    unit_t              s4_span_next, s4_span_reg;
    unit_t              s4_q_reg, s4_p_reg;
    hslrgb_pkg::byte_t  s4_abyte_reg;
    num_t               hq_rem;

    // Stage 5: channel positions.
    unit_t              s5_t_next [NCH];
    unit_t              s5_t_reg  [NCH];
    unit_t              s5_q_reg, s5_p_reg, s5_span_reg;
    hslrgb_pkg::byte_t  s5_abyte_reg;
    unit_t              t_red;

    // Stage 6: ramp selection.
    chan_ctl_t          s6_ctl_next [NCH];
    chan_ctl_t          s6_ctl_reg  [NCH];
    unit_t              s6_q_reg, s6_p_reg, s6_span_reg;
    hslrgb_pkg::byte_t  s6_abyte_reg;

    // Stage 7: ramp products.
    unit_t              s7_inc_next [NCH];
    unit_t              s7_inc_reg  [NCH];
    logic [NCH-1:0]     s7_use_q_reg;
    unit_t              s7_q_reg, s7_p_reg;
    hslrgb_pkg::byte_t  s7_abyte_reg;
    prod_t              ramp_prod [NCH];

    // Stage 8: clamped channel values.
    unit_t              s8_v_next [NCH];
    unit_t              s8_v_reg  [NCH];
    hslrgb_pkg::byte_t  s8_abyte_reg;
    wide_t              v_sum [NCH];

    // Stage 9: output bytes.
    hslrgb_pkg::byte_t  s9_byte_next [NCH];
    hslrgb_pkg::byte_t  s9_byte_reg  [NCH];
    hslrgb_pkg::byte_t  s9_abyte_reg;

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb
    begin
        stage_en[NS-1] = !vld_reg[NS-1] || rgba.ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    assign hsla.ready = stage_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                vld_reg[0] <= hsla.valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (stage_en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Offset the hue by 23 turns so it is never negative, then estimate the
    // turn count as ((hue >> 9) * 1456) >> 16, which is low by at most one.
    always_comb
    begin
        s1_hue_next   = {1'b0, ~hsla.hue[hslrgb_pkg::HUE_W-1],
                         hsla.hue[hslrgb_pkg::HUE_W-2:0]} + hslrgb_pkg::HUE_BIAS;
        k_prod        = 23'(s1_hue_next[20:9]) * 23'(hslrgb_pkg::HUE_RECIP);
        s1_k_next     = k_prod[21:16];
        s1_sat_next   = unit_from_q12(hsla.saturation);
        s1_lit_next   = unit_from_q12(hsla.lightness);
        s1_alpha_next = unit_from_q12(hsla.opacity);
    end

    // Remove the turns with one correction step; form l * s.
    always_comb
    begin
        hue_rem = s1_hue_reg - hslrgb_pkg::hoff_t'(s1_k_reg) * hslrgb_pkg::HUE_TURN;
        if (hue_rem >= hslrgb_pkg::HUE_TURN)
            s2_hmod_next = hslrgb_pkg::hmod_t'(hue_rem - hslrgb_pkg::HUE_TURN);
        else
            s2_hmod_next = hslrgb_pkg::hmod_t'(hue_rem);
        ls_prod       = prod_t'(s1_lit_reg) * prod_t'(s1_sat_reg);
        s2_ls_next    = ls_prod[2*F:F];
        s2_abyte_next = to_byte(s1_alpha_reg);
    end

    // Scale the wrapped hue: (hmod << (F-9)) / 45 by a reciprocal multiply.
    // Form q from l, s and l * s, and p = 2l - q.
    always_comb
    begin
        s3_num_next  = {s2_hmod_reg, {(F-9){1'b0}}};
        q_prod       = qprod_t'(s3_num_next) * qprod_t'(HUE_RECIP_F);
        s3_qhat_next = q_prod[2*F+5:F+6];
        if (s2_lit_reg < HALF)
            q_wide = wide_t'(s2_lit_reg) + wide_t'(s2_ls_reg);
        else
            q_wide = wide_t'(s2_lit_reg) + wide_t'(s2_sat_reg) - wide_t'(s2_ls_reg);
        p_wide    = {s2_lit_reg, 1'b0} - q_wide;
        s3_q_next = q_wide[F:0];
        s3_p_next = p_wide[F:0];
    end

    // Correct the hue quotient; the span is never negative.
    always_comb
    begin
        hq_rem       = s3_num_reg - num_t'(s3_qhat_reg) * num_t'(hslrgb_pkg::HUE_DIV);
        s4_h_next    = s3_qhat_reg + frac_t'(hq_rem >= num_t'(hslrgb_pkg::HUE_DIV));
        s4_span_next = s3_q_reg - s3_p_reg;
    end

    // Channel positions: red leads by a third, blue trails by a third. A red
    // position equal to one is kept as is.
    always_comb
    begin
        t_red = unit_t'({1'b0, s4_h_reg}) + THIRD;
        if (t_red > ONE)
            s5_t_next[0] = t_red - ONE;
        else
            s5_t_next[0] = t_red;
        s5_t_next[1] = unit_t'({1'b0, s4_h_reg});
        if (unit_t'({1'b0, s4_h_reg}) >= THIRD)
            s5_t_next[2] = unit_t'({1'b0, s4_h_reg}) - THIRD;
        else
            s5_t_next[2] = unit_t'({1'b0, s4_h_reg}) + (ONE - THIRD);
    end

    // Ramp segment per channel, then the ramp product, then the final value.
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            s6_ctl_next[c] = chan_ctl(s5_t_reg[c]);
            ramp_prod[c]   = prod_t'(s6_span_reg) * prod_t'(s6_ctl_reg[c].d);
            s7_inc_next[c] = ramp_prod[c][2*F:F];
            if (s7_use_q_reg[c])
                v_sum[c] = wide_t'(s7_q_reg);
            else
                v_sum[c] = wide_t'(s7_p_reg) + wide_t'(s7_inc_reg[c]);
            if (v_sum[c] > wide_t'(ONE))
                s8_v_next[c] = ONE;
            else
                s8_v_next[c] = v_sum[c][F:0];
            s9_byte_next[c] = to_byte(s8_v_reg[c]);
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s1_hue_reg   <= s1_hue_next;
            s1_k_reg     <= s1_k_next;
            s1_sat_reg   <= s1_sat_next;
            s1_lit_reg   <= s1_lit_next;
            s1_alpha_reg <= s1_alpha_next;
        end
        if (stage_en[1])
        begin
            s2_hmod_reg  <= s2_hmod_next;
            s2_ls_reg    <= s2_ls_next;
            s2_sat_reg   <= s1_sat_reg;
            s2_lit_reg   <= s1_lit_reg;
            s2_abyte_reg <= s2_abyte_next;
        end
        if (stage_en[2])
        begin
            s3_num_reg   <= s3_num_next;
            s3_qhat_reg  <= s3_qhat_next;
            s3_q_reg     <= s3_q_next;
            s3_p_reg     <= s3_p_next;
            s3_abyte_reg <= s2_abyte_reg;
        end
        if (stage_en[3])
        begin
            s4_h_reg     <= s4_h_next;
            s4_span_reg  <= s4_span_next;
            s4_q_reg     <= s3_q_reg;
            s4_p_reg     <= s3_p_reg;
            s4_abyte_reg <= s3_abyte_reg;
        end
        if (stage_en[4])
        begin
            s5_t_reg     <= s5_t_next;
            s5_q_reg     <= s4_q_reg;
            s5_p_reg     <= s4_p_reg;
            s5_span_reg  <= s4_span_reg;
            s5_abyte_reg <= s4_abyte_reg;
        end
        if (stage_en[5])
        begin
            s6_ctl_reg   <= s6_ctl_next;
            s6_q_reg     <= s5_q_reg;
            s6_p_reg     <= s5_p_reg;
            s6_span_reg  <= s5_span_reg;
            s6_abyte_reg <= s5_abyte_reg;
        end
        if (stage_en[6])
        begin
            s7_inc_reg   <= s7_inc_next;
            for (int c = 0; c < NCH; c++)
            begin
                s7_use_q_reg[c] <= s6_ctl_reg[c].use_q;
            end
            s7_q_reg     <= s6_q_reg;
            s7_p_reg     <= s6_p_reg;
            s7_abyte_reg <= s6_abyte_reg;
        end
        if (stage_en[7])
        begin
            s8_v_reg     <= s8_v_next;
            s8_abyte_reg <= s7_abyte_reg;
        end
        if (stage_en[8])
        begin
            s9_byte_reg  <= s9_byte_next;
            s9_abyte_reg <= s8_abyte_reg;
        end
    end

    // Output channel.
    assign rgba.valid     = vld_reg[NS-1];
    assign rgba.red       = s9_byte_reg[0];
    assign rgba.green     = s9_byte_reg[1];
    assign rgba.blue      = s9_byte_reg[2];
    assign rgba.alpha_out = s9_abyte_reg;

    // An accepted color always lands in the first stage.
    `ASSERT_NEXT(a_accept_enters, clk, rst_n, hsla.valid && hsla.ready, vld_reg[0])
    // The turn correction leaves the hue inside one turn.
    `ASSERT_HOLDS(a_hue_wrapped, clk, rst_n, !vld_reg[1] || (s2_hmod_reg < hslrgb_pkg::HUE_TURN))
    // q never falls below p, and the span stays within one unit.
    `ASSERT_HOLDS(a_span_range, clk, rst_n, !vld_reg[3] || (s4_span_reg <= ONE && s4_q_reg >= s4_p_reg))

endmodule
